/* src/npc_pkg.sv */
// Package of types and constants for the nearest palette colour block.
package npc_pkg;

  localparam int ACTION_W      = 2;
  localparam int ENTRY_INDEX_W = 7;
  localparam int COMPONENT_W   = 8;
  localparam int COLOR_CODE_W  = 7;
  localparam int COLOR_W       = 3 * COMPONENT_W;
  localparam int COUNT_W       = 8;
  localparam int LIMIT_W       = 9;
  localparam int CFG_DATA_W    = 9;
  localparam int CFG_INDEX_W   = 1;
  localparam int SQUARE_W      = 2 * COMPONENT_W;
  localparam int DIST_W        = 2 * LIMIT_W;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_LIMIT = 1'd1;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET    = 8'd128;
  localparam logic [LIMIT_W-1:0] DISTANCE_LIMIT_RESET = 9'd100;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [COMPONENT_W-1:0]   red_in;
    logic [COMPONENT_W-1:0]   green_in;
    logic [COMPONENT_W-1:0]   blue_in;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_CODE_W-1:0] color_code;
    logic                    matched;
    logic [COMPONENT_W-1:0]  red_out;
    logic [COMPONENT_W-1:0]  green_out;
    logic [COMPONENT_W-1:0]  blue_out;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

/* src/nearest_palette_color_top.sv */
// Top level of the nearest palette colour block: palette memory, scan sequencer and distance unit.
// A write word is written to the palette memory in the accept cycle. A read word reads the palette
// memory in the accept cycle and then loads the output register. For a lookup word, n is
// entry_count saturated to PALETTE_DEPTH; when n is at least one, one palette entry is read
// through the single memory read port per cycle and passes through the shared two-stage distance
// unit (squares, then sum and compare), which then drains before the output register is loaded.
// When n is zero the scan is skipped. The input side stalls while a read or a lookup is in
// progress, and a finished result waits in the output register while the next word is accepted.
module nearest_palette_color_top import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int N_W       = COUNT_W + 1;
  localparam int INDEX_SPAN = 2 ** ENTRY_INDEX_W;

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0] entry_count;
  logic [LIMIT_W-1:0] distance_limit;

  logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rdata;

  logic [AW-1:0] slot_tab [INDEX_SPAN];
  logic [AW-1:0] slot;

  logic          in_acc;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          start_lookup;
  logic          start_read;
  logic          load_out;

  logic [N_W-1:0] n_ext;
  logic [N_W-1:0] n_sat;
  logic           n_zero;

  logic [AW-1:0] scan_idx;
  logic [AW-1:0] scan_last;
  logic          is_read;

  logic [COMPONENT_W-1:0] lk_red;
  logic [COMPONENT_W-1:0] lk_green;
  logic [COMPONENT_W-1:0] lk_blue;

  logic                p1_valid;
  logic [AW-1:0]       p1_idx;
  logic                p2_valid;
  logic [AW-1:0]       p2_idx;
  logic [SQUARE_W-1:0] sq_red;
  logic [SQUARE_W-1:0] sq_green;
  logic [SQUARE_W-1:0] sq_blue;
  logic [DIST_W-1:0]   dist_sum;

  logic [DIST_W-1:0] best;
  logic [AW-1:0]     best_idx;
  logic              hit;

  function automatic logic [COMPONENT_W-1:0] abs_diff(input logic [COMPONENT_W-1:0] a,
                                                      input logic [COMPONENT_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SQUARE_W-1:0] square(input logic [COMPONENT_W-1:0] d);
    return SQUARE_W'(d) * SQUARE_W'(d);
  endfunction

  for (genvar i = 0; i < INDEX_SPAN; i++) begin : g_slot
    assign slot_tab[i] = AW'(i % PALETTE_DEPTH);
  end

  assign slot     = slot_tab[in_data.entry_index];
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign n_ext  = {1'b0, entry_count};
  assign n_sat  = (n_ext > N_W'(PALETTE_DEPTH)) ? N_W'(PALETTE_DEPTH) : n_ext;
  assign n_zero = (n_sat == '0);

  assign dist_sum = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.action)
            ACT_LOOKUP: state_next = n_zero ? ST_DRAIN : ST_SCAN;
            ACT_READ:   state_next = ST_FINISH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx == scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_valid && !p2_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = slot;
    start_lookup = 1'b0;
    start_read   = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.action)
            ACT_WRITE: wr_en = 1'b1;
            ACT_LOOKUP: start_lookup = 1'b1;
            ACT_READ: begin
              start_read = 1'b1;
              rd_en      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_idx;
      end
      ST_FINISH: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[slot] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    if (rd_en) begin
      rdata <= palette[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_count    <= ENTRY_COUNT_RESET;
      distance_limit <= DISTANCE_LIMIT_RESET;
      p1_valid       <= 1'b0;
      p2_valid       <= 1'b0;
      out_valid      <= 1'b0;
      scan_idx       <= '0;
      is_read        <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= (state == ST_SCAN);
      p2_valid <= p1_valid;
      if (cfg_write) begin
        case (cfg_index)
          REG_ENTRY_COUNT:    entry_count <= cfg_data[COUNT_W-1:0];
          REG_DISTANCE_LIMIT: distance_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (start_lookup) begin
        scan_idx <= '0;
        is_read  <= 1'b0;
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (start_read) begin
        is_read <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_lookup) begin
      scan_last <= AW'(n_sat - 1'b1);
      lk_red    <= in_data.red_in;
      lk_green  <= in_data.green_in;
      lk_blue   <= in_data.blue_in;
    end
    p1_idx   <= scan_idx;
    p2_idx   <= p1_idx;
    sq_red   <= square(abs_diff(lk_red, rdata[23:16]));
    sq_green <= square(abs_diff(lk_green, rdata[15:8]));
    sq_blue  <= square(abs_diff(lk_blue, rdata[7:0]));
    if (start_lookup) begin
      best     <= DIST_W'({{LIMIT_W{1'b0}}, distance_limit} *
                          {{LIMIT_W{1'b0}}, distance_limit});
      best_idx <= '0;
      hit      <= 1'b0;
    end else if (p2_valid && (dist_sum < best)) begin
      best     <= dist_sum;
      best_idx <= p2_idx;
      hit      <= 1'b1;
    end
    if (load_out) begin
      if (is_read) begin
        out_data.color_code <= '0;
        out_data.matched    <= 1'b0;
        out_data.red_out    <= rdata[23:16];
        out_data.green_out  <= rdata[15:8];
        out_data.blue_out   <= rdata[7:0];
      end else begin
        out_data.color_code <= COLOR_CODE_W'(best_idx);
        out_data.matched    <= hit;
        out_data.red_out    <= '0;
        out_data.green_out  <= '0;
        out_data.blue_out   <= '0;
      end
    end
  end

endmodule
